FILE: src/avc_sps_pkg.sv
// shared types and constants of the sps size parser
// no dependencies
package avc_sps_pkg;

  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TYPE  = 2'd1,
    ST_BAD_LEVEL = 2'd2,
    ST_TRUNC     = 2'd3
  } sps_status_e;

  typedef enum logic [5:0] {
    SX_HDR, SX_PROFILE, SX_CONSTR, SX_LEVEL, SX_SPS_ID, SX_CHROMA, SX_RESID,
    SX_BDL, SX_BDC, SX_BYPASS, SX_MATRIX, SX_LIST_FLAG, SX_DELTA, SX_LOG2FN,
    SX_POC_TYPE, SX_POC_LSB, SX_ALWAYS0, SX_OFF_NONREF, SX_OFF_T2B,
    SX_NUM_CYCLE, SX_OFF_REF, SX_NUM_REF, SX_GAPS, SX_WIDTH, SX_HEIGHT,
    SX_FRAME_MBS, SX_MBAFF, SX_DIRECT, SX_CROP, SX_CROP_L, SX_CROP_R,
    SX_CROP_T, SX_CROP_B, SX_DONE
  } syntax_e;

  localparam logic [4:0] NalTypeMask = 5'h1F;
  localparam logic [4:0] NalTypeSps  = 5'd7;
  localparam logic [7:0] MaxLevel    = 8'd51;
  localparam logic [7:0] ProfHigh    = 8'd100;
  localparam logic [7:0] ProfHigh10  = 8'd110;
  localparam logic [7:0] ProfHigh422 = 8'd122;
  localparam logic [7:0] ProfHigh444 = 8'd144;
  localparam logic [7:0] ScaleInit   = 8'd8;
  localparam logic [3:0] NumLists    = 4'd8;
  localparam logic [3:0] NumSmall    = 4'd6;
  localparam logic [6:0] SmallSize   = 7'd16;
  localparam logic [6:0] LargeSize   = 7'd64;
  localparam logic [3:0] MaxZeros    = 4'd15;
  localparam logic [3:0] BitsPerByte = 4'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // latch a new byte
    logic step;    // parse one bit
    logic finish;  // end-of-byte handling (last byte mark)
  } dp_cmd_t;

  typedef struct packed {
    logic finished;
    logic emit;
  } dp_sts_t;

  // width of fixed-length elements, zero for exp-golomb ones
  function automatic logic [3:0] fixed_width(syntax_e s);
    logic [3:0] w;
    unique case (s)
      SX_HDR, SX_PROFILE, SX_CONSTR, SX_LEVEL: w = 4'd8;
      SX_RESID, SX_BYPASS, SX_MATRIX, SX_LIST_FLAG, SX_ALWAYS0, SX_GAPS,
      SX_FRAME_MBS, SX_MBAFF, SX_DIRECT, SX_CROP: w = 4'd1;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: src/avc_sps_ctrl.sv
// controller: byte sequencing, bit counting and result valid
// depends on avc_sps_pkg
module avc_sps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output avc_sps_pkg::dp_cmd_t cmd_o,
  input  avc_sps_pkg::dp_sts_t sts_i
);
  import avc_sps_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} ctrl_state_e;

  ctrl_state_e state_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  logic        can_go;
  logic        end_byte;

  assign can_go   = !out_valid_q || !out_stall_i;
  assign end_byte = (cnt_q == BitsPerByte) || sts_i.finished;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_RUN: begin
        if (can_go) begin
          cmd_o.finish = end_byte;
          cmd_o.step   = !end_byte;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (sts_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            cnt_q   <= '0;
          end
        end
        S_RUN: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end else if (cmd_o.step) begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.emit |-> !(out_valid_q && out_stall_i))
    else $error("result would overwrite a pending result");
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.emit |=> out_valid_q)
    else $error("result lost");
  a_no_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> (!sts_i.finished && !cnt_q[3]))
    else $error("bit parsed after end");

endmodule

FILE: src/avc_sps_dp.sv
// datapath: bitwise sps syntax walk, exp-golomb decode and result registers
// depends on avc_sps_pkg
module avc_sps_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  avc_sps_pkg::dp_cmd_t cmd_i,
  output avc_sps_pkg::dp_sts_t sts_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 last_byte_i,
  output logic [1:0]           status_o,
  output logic [7:0]           profile_o,
  output logic [7:0]           level_o,
  output logic [19:0]          coded_width_o,
  output logic [19:0]          coded_height_o,
  output logic signed [20:0]   disp_width_o,
  output logic signed [20:0]   disp_height_o
);
  import avc_sps_pkg::*;

  logic [7:0]  byte_q;
  logic        last_q;
  syntax_e     step_q, step_d;
  logic [3:0]  bl_q, bl_d, zr_q, zr_d;
  logic        inp_q, inp_d;
  logic [15:0] fv_q, fv_d;
  logic [7:0]  prof_q, prof_d, lvl_q, lvl_d, last_sc_q, last_sc_d;
  logic [3:0]  li_q, li_d;
  logic [6:0]  lpos_q, lpos_d;
  logic [15:0] cyc_q, cyc_d;
  logic [19:0] wid_q, wid_d, hgt_q, hgt_d;
  logic [17:0] crh_q, crh_d, crv_q, crv_d;
  logic        fin_q, fin_d;

  logic        bit_in, vdone, ent, emit_step, emit;
  syntax_e     ent_step;
  sps_status_e stat_step, stat;
  logic [15:0] v, fsh;
  logic [7:0]  half, delta, nscale;
  logic [3:0]  li_inc;
  logic [6:0]  pos_inc, lim;

  always_comb begin
    step_d = step_q; bl_d = bl_q; zr_d = zr_q; inp_d = inp_q; fv_d = fv_q;
    prof_d = prof_q; lvl_d = lvl_q; last_sc_d = last_sc_q; li_d = li_q;
    lpos_d = lpos_q; cyc_d = cyc_q; wid_d = wid_q; hgt_d = hgt_q;
    crh_d = crh_q; crv_d = crv_q; fin_d = fin_q;
    bit_in = byte_q[7];
    fsh = {fv_q[14:0], bit_in};
    vdone = 1'b0; v = '0; ent = 1'b0; ent_step = step_q;
    emit_step = 1'b0; stat_step = ST_OK;
    half = '0; delta = '0; nscale = '0;
    li_inc = li_q + 4'd1;
    pos_inc = lpos_q + 7'd1;
    lim = (li_q < NumSmall) ? SmallSize : LargeSize;

    if (cmd_i.step) begin
      if (inp_q) begin
        if (!bit_in && zr_q != MaxZeros) begin
          zr_d = zr_q + 4'd1;
        end else begin
          inp_d = 1'b0;
          if (zr_q == 4'd0) begin
            vdone = 1'b1;
          end else begin
            bl_d = zr_q;
            fv_d = 16'd1;
          end
        end
      end else begin
        fv_d = fsh;
        bl_d = bl_q - 4'd1;
        if (bl_q == 4'd1) begin
          vdone = 1'b1;
          v = (fixed_width(step_q) != 4'd0) ? fsh : fsh - 16'd1;
        end
      end

      if (vdone) begin
        unique case (step_q)
          SX_HDR: begin
            if ((v[4:0] & NalTypeMask) != NalTypeSps) begin
              emit_step = 1'b1; stat_step = ST_BAD_TYPE;
            end else begin
              ent = 1'b1; ent_step = SX_PROFILE;
            end
          end
          SX_PROFILE: begin prof_d = v[7:0]; ent = 1'b1; ent_step = SX_CONSTR; end
          SX_CONSTR: begin ent = 1'b1; ent_step = SX_LEVEL; end
          SX_LEVEL: begin
            lvl_d = v[7:0];
            if (v[7:0] > MaxLevel) begin
              emit_step = 1'b1; stat_step = ST_BAD_LEVEL;
            end else begin
              ent = 1'b1; ent_step = SX_SPS_ID;
            end
          end
          SX_SPS_ID: begin
            ent = 1'b1;
            ent_step = (prof_q == ProfHigh || prof_q == ProfHigh10 ||
                        prof_q == ProfHigh422 || prof_q == ProfHigh444) ?
                       SX_CHROMA : SX_LOG2FN;
          end
          SX_CHROMA: begin ent = 1'b1; ent_step = (v == 16'd3) ? SX_RESID : SX_BDL; end
          SX_RESID: begin ent = 1'b1; ent_step = SX_BDL; end
          SX_BDL: begin ent = 1'b1; ent_step = SX_BDC; end
          SX_BDC: begin ent = 1'b1; ent_step = SX_BYPASS; end
          SX_BYPASS: begin ent = 1'b1; ent_step = SX_MATRIX; end
          SX_MATRIX: begin
            ent = 1'b1;
            if (v != 16'd0) begin
              li_d = '0; ent_step = SX_LIST_FLAG;
            end else begin
              ent_step = SX_LOG2FN;
            end
          end
          SX_LIST_FLAG: begin
            ent = 1'b1;
            if (v != 16'd0) begin
              last_sc_d = ScaleInit; lpos_d = '0; ent_step = SX_DELTA;
            end else begin
              li_d = li_inc;
              ent_step = (li_inc >= NumLists) ? SX_LOG2FN : SX_LIST_FLAG;
            end
          end
          SX_DELTA: begin
            // signed code to delta, modulo 256
            half = v[8:1];
            delta = v[0] ? half + 8'd1 : 8'd0 - half;
            nscale = last_sc_q + delta;
            if (nscale != 8'd0) last_sc_d = nscale;
            lpos_d = pos_inc;
            ent = 1'b1;
            if (pos_inc >= lim || nscale == 8'd0) begin
              li_d = li_inc;
              ent_step = (li_inc >= NumLists) ? SX_LOG2FN : SX_LIST_FLAG;
            end else begin
              ent_step = SX_DELTA;
            end
          end
          SX_LOG2FN: begin ent = 1'b1; ent_step = SX_POC_TYPE; end
          SX_POC_TYPE: begin
            ent = 1'b1;
            if (v == 16'd0) ent_step = SX_POC_LSB;
            else if (v == 16'd1) ent_step = SX_ALWAYS0;
            else ent_step = SX_NUM_REF;
          end
          SX_POC_LSB: begin ent = 1'b1; ent_step = SX_NUM_REF; end
          SX_ALWAYS0: begin ent = 1'b1; ent_step = SX_OFF_NONREF; end
          SX_OFF_NONREF: begin ent = 1'b1; ent_step = SX_OFF_T2B; end
          SX_OFF_T2B: begin ent = 1'b1; ent_step = SX_NUM_CYCLE; end
          SX_NUM_CYCLE: begin
            cyc_d = v; ent = 1'b1;
            ent_step = (v == 16'd0) ? SX_NUM_REF : SX_OFF_REF;
          end
          SX_OFF_REF: begin
            cyc_d = cyc_q - 16'd1; ent = 1'b1;
            ent_step = (cyc_q == 16'd1) ? SX_NUM_REF : SX_OFF_REF;
          end
          SX_NUM_REF: begin ent = 1'b1; ent_step = SX_GAPS; end
          SX_GAPS: begin ent = 1'b1; ent_step = SX_WIDTH; end
          SX_WIDTH: begin
            wid_d = {v + 16'd1, 4'd0}; ent = 1'b1; ent_step = SX_HEIGHT;
          end
          SX_HEIGHT: begin
            hgt_d = {v + 16'd1, 4'd0}; ent = 1'b1; ent_step = SX_FRAME_MBS;
          end
          SX_FRAME_MBS: begin
            ent = 1'b1; ent_step = (v != 16'd0) ? SX_DIRECT : SX_MBAFF;
          end
          SX_MBAFF: begin ent = 1'b1; ent_step = SX_DIRECT; end
          SX_DIRECT: begin ent = 1'b1; ent_step = SX_CROP; end
          SX_CROP: begin
            if (v == 16'd0) begin
              emit_step = 1'b1;
            end else begin
              ent = 1'b1; ent_step = SX_CROP_L;
            end
          end
          SX_CROP_L: begin crh_d = crh_q + {2'd0, v}; ent = 1'b1; ent_step = SX_CROP_R; end
          SX_CROP_R: begin crh_d = crh_q + {2'd0, v}; ent = 1'b1; ent_step = SX_CROP_T; end
          SX_CROP_T: begin crv_d = crv_q + {2'd0, v}; ent = 1'b1; ent_step = SX_CROP_B; end
          SX_CROP_B: begin crv_d = crv_q + {2'd0, v}; emit_step = 1'b1; end
          default: ent = 1'b0;
        endcase
      end

      if (ent) begin
        step_d = ent_step;
        zr_d   = '0;
        fv_d   = '0;
        bl_d   = fixed_width(ent_step);
        inp_d  = (fixed_width(ent_step) == 4'd0);
      end
      if (emit_step) begin
        step_d = SX_DONE;
        fin_d  = 1'b1;
      end
    end

    emit = emit_step || (cmd_i.finish && last_q && !fin_q);
    stat = emit_step ? stat_step : ST_TRUNC;
  end

  assign sts_o.finished = fin_q;
  assign sts_o.emit     = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0; last_q <= 1'b0;
      step_q <= SX_HDR; bl_q <= fixed_width(SX_HDR); zr_q <= '0; inp_q <= 1'b0;
      fv_q <= '0; prof_q <= '0; lvl_q <= '0; last_sc_q <= ScaleInit; li_q <= '0;
      lpos_q <= '0; cyc_q <= '0; wid_q <= '0; hgt_q <= '0; crh_q <= '0;
      crv_q <= '0; fin_q <= 1'b0;
    end else if (cmd_i.load) begin
      byte_q <= in_byte_i;
      last_q <= last_byte_i;
    end else if (cmd_i.finish) begin
      if (last_q) begin
        step_q <= SX_HDR; bl_q <= fixed_width(SX_HDR); zr_q <= '0; inp_q <= 1'b0;
        fv_q <= '0; prof_q <= '0; lvl_q <= '0; last_sc_q <= ScaleInit; li_q <= '0;
        lpos_q <= '0; cyc_q <= '0; wid_q <= '0; hgt_q <= '0; crh_q <= '0;
        crv_q <= '0; fin_q <= 1'b0;
      end
    end else if (cmd_i.step) begin
      byte_q <= {byte_q[6:0], 1'b0};
      step_q <= step_d; bl_q <= bl_d; zr_q <= zr_d; inp_q <= inp_d; fv_q <= fv_d;
      prof_q <= prof_d; lvl_q <= lvl_d; last_sc_q <= last_sc_d; li_q <= li_d;
      lpos_q <= lpos_d; cyc_q <= cyc_d; wid_q <= wid_d; hgt_q <= hgt_d;
      crh_q <= crh_d; crv_q <= crv_d; fin_q <= fin_d;
    end
  end

  // result registers, loaded from the post-step values
  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_o       <= stat;
      profile_o      <= prof_d;
      level_o        <= lvl_d;
      coded_width_o  <= wid_d;
      coded_height_o <= hgt_d;
      disp_width_o   <= signed'({1'b0, wid_d} - {2'b0, crh_d, 1'b0});
      disp_height_o  <= signed'({1'b0, hgt_d} - {2'b0, crv_d, 1'b0});
    end
  end

endmodule

FILE: src/avc_sps_size_parser.sv
// top level of the h.264 sps size parser
// depends on avc_sps_pkg, avc_sps_ctrl, avc_sps_dp
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_byte_i, last_byte_i
// out      output     out_valid_o / out_stall_i status_o .. disp_height_o
//
// a byte is accepted, then walked one bit per step through the
//   shared bit step of the syntax walk (stops early once a result is made),
//   then given end-of-byte handling
// a new byte is accepted while a result waits in the output register; the
//   bit walk and end-of-byte handling pause while that result waits stalled
// reset is asynchronous and puts the parser at the nal header byte
// after a last-byte mark the parser returns to the header byte
module avc_sps_size_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         profile_o,
  output logic [7:0]         level_o,
  output logic [19:0]        coded_width_o,
  output logic [19:0]        coded_height_o,
  output logic signed [20:0] disp_width_o,
  output logic signed [20:0] disp_height_o
);
  import avc_sps_pkg::*;

  dp_cmd_t cmd;  // controller to datapath
  dp_sts_t sts;  // datapath to controller

  // sequencing of bytes and bits, result valid
  avc_sps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // syntax walk, exp-golomb decode and result payload
  avc_sps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (in_byte_i),
    .last_byte_i    (last_byte_i),
    .status_o       (status_o),
    .profile_o      (profile_o),
    .level_o        (level_o),
    .coded_width_o  (coded_width_o),
    .coded_height_o (coded_height_o),
    .disp_width_o   (disp_width_o),
    .disp_height_o  (disp_height_o)
  );

endmodule

FILE: test/avc_sps_size_parser_tb.sv
// testbench of the h.264 sps size parser: builds sps nal units bit by bit,
// predicts one size item per nal unit and checks every output item
// depends on avc_sps_pkg and avc_sps_size_parser
module avc_sps_size_parser_tb;
  import avc_sps_pkg::*;

  typedef struct packed {
    sps_status_e        status;
    logic [7:0]         profile;
    logic [7:0]         level;
    logic [19:0]        coded_w;
    logic [19:0]        coded_h;
    logic signed [20:0] disp_w;
    logic signed [20:0] disp_h;
  } sps_size_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_byte_i = '0;
  logic               last_byte_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [7:0]         profile_o;
  logic [7:0]         level_o;
  logic [19:0]        coded_width_o;
  logic [19:0]        coded_height_o;
  logic signed [20:0] disp_width_o;
  logic signed [20:0] disp_height_o;

  avc_sps_size_parser i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_byte_i, .last_byte_i,
    .out_valid_o, .out_stall_i, .status_o, .profile_o, .level_o,
    .coded_width_o, .coded_height_o, .disp_width_o, .disp_height_o
  );

  always #1 clk_i = ~clk_i;

  // sizes predicted but not yet seen on the output
  sps_size_t pending_sizes[$];
  int        mismatches = 0;
  int        bytes_sent = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_cycles = 0;
  logic      bit_buf[$];

  // ---------------- predictor state ----------------
  syntax_e     p_step;
  int unsigned p_bits_left, p_zeros;
  logic        p_prefix, p_done;
  logic [31:0] p_value;
  logic [7:0]  p_profile, p_level, p_last_scale, p_next_scale;
  logic [3:0]  p_list;
  logic [6:0]  p_pos;
  logic [15:0] p_cycles;
  logic [19:0] p_width, p_height;
  logic [17:0] p_crop_h, p_crop_v;

  // width of fixed-length syntax elements, zero means exp-golomb
  function automatic int unsigned elem_bits(syntax_e s);
    case (s)
      SX_HDR, SX_PROFILE, SX_CONSTR, SX_LEVEL: return 8;
      SX_RESID, SX_BYPASS, SX_MATRIX, SX_LIST_FLAG, SX_ALWAYS0, SX_GAPS,
      SX_FRAME_MBS, SX_MBAFF, SX_DIRECT, SX_CROP: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic goto_elem(syntax_e s);
    p_step = s;
    p_zeros = 0;
    p_value = '0;
    p_bits_left = elem_bits(s);
    p_prefix = (p_bits_left == 0);
  endtask

  task automatic clear_parse();
    p_profile = '0; p_level = '0; p_list = '0; p_pos = '0;
    p_last_scale = ScaleInit; p_next_scale = ScaleInit; p_cycles = '0;
    p_width = '0; p_height = '0; p_crop_h = '0; p_crop_v = '0;
    p_done = 1'b0;
    goto_elem(SX_HDR);
  endtask

  task automatic post_size(sps_status_e st);
    sps_size_t r;
    logic [31:0] dw, dh;
    dw = 32'(p_width) - 2 * 32'(p_crop_h);
    dh = 32'(p_height) - 2 * 32'(p_crop_v);
    r = '{st, p_profile, p_level, p_width, p_height, dw[20:0], dh[20:0]};
    pending_sizes.push_back(r);
    p_done = 1'b1;
    p_step = SX_DONE;
  endtask

  task automatic next_scaling_list();
    p_list = p_list + 4'd1;
    if (p_list >= NumLists) goto_elem(SX_LOG2FN);
    else goto_elem(SX_LIST_FLAG);
  endtask

  // one syntax element finished with value v
  task automatic elem_done(logic [31:0] v);
    logic [31:0] delta;
    case (p_step)
      SX_HDR: begin
        if ((v[4:0] & NalTypeMask) != NalTypeSps) post_size(ST_BAD_TYPE);
        else goto_elem(SX_PROFILE);
      end
      SX_PROFILE: begin
        p_profile = v[7:0];
        goto_elem(SX_CONSTR);
      end
      SX_CONSTR: goto_elem(SX_LEVEL);
      SX_LEVEL: begin
        p_level = v[7:0];
        if (p_level > MaxLevel) post_size(ST_BAD_LEVEL);
        else goto_elem(SX_SPS_ID);
      end
      SX_SPS_ID: begin
        if (p_profile == ProfHigh || p_profile == ProfHigh10 ||
            p_profile == ProfHigh422 || p_profile == ProfHigh444)
          goto_elem(SX_CHROMA);
        else goto_elem(SX_LOG2FN);
      end
      SX_CHROMA: goto_elem(v == 3 ? SX_RESID : SX_BDL);
      SX_RESID: goto_elem(SX_BDL);
      SX_BDL: goto_elem(SX_BDC);
      SX_BDC: goto_elem(SX_BYPASS);
      SX_BYPASS: goto_elem(SX_MATRIX);
      SX_MATRIX: begin
        if (v != 0) begin
          p_list = '0;
          goto_elem(SX_LIST_FLAG);
        end else goto_elem(SX_LOG2FN);
      end
      SX_LIST_FLAG: begin
        if (v != 0) begin
          p_last_scale = ScaleInit; p_next_scale = ScaleInit; p_pos = '0;
          goto_elem(SX_DELTA);
        end else next_scaling_list();
      end
      SX_DELTA: begin
        // signed code mapping, then the mod-256 scale walk
        delta = v[0] ? (v + 1) >> 1 : 32'd0 - (v >> 1);
        p_next_scale = 8'(32'(p_last_scale) + delta);
        if (p_next_scale != 0) p_last_scale = p_next_scale;
        p_pos = p_pos + 7'd1;
        if (p_pos >= ((p_list < NumSmall) ? SmallSize : LargeSize) || p_next_scale == 0)
          next_scaling_list();
        else goto_elem(SX_DELTA);
      end
      SX_LOG2FN: goto_elem(SX_POC_TYPE);
      SX_POC_TYPE: begin
        if (v == 0) goto_elem(SX_POC_LSB);
        else if (v == 1) goto_elem(SX_ALWAYS0);
        else goto_elem(SX_NUM_REF);
      end
      SX_POC_LSB: goto_elem(SX_NUM_REF);
      SX_ALWAYS0: goto_elem(SX_OFF_NONREF);
      SX_OFF_NONREF: goto_elem(SX_OFF_T2B);
      SX_OFF_T2B: goto_elem(SX_NUM_CYCLE);
      SX_NUM_CYCLE: begin
        p_cycles = v[15:0];
        goto_elem(p_cycles == 0 ? SX_NUM_REF : SX_OFF_REF);
      end
      SX_OFF_REF: begin
        p_cycles = p_cycles - 16'd1;
        goto_elem(p_cycles == 0 ? SX_NUM_REF : SX_OFF_REF);
      end
      SX_NUM_REF: goto_elem(SX_GAPS);
      SX_GAPS: goto_elem(SX_WIDTH);
      SX_WIDTH: begin
        p_width = 20'((v + 1) << 4);
        goto_elem(SX_HEIGHT);
      end
      SX_HEIGHT: begin
        p_height = 20'((v + 1) << 4);
        goto_elem(SX_FRAME_MBS);
      end
      SX_FRAME_MBS: goto_elem(v != 0 ? SX_DIRECT : SX_MBAFF);
      SX_MBAFF: goto_elem(SX_DIRECT);
      SX_DIRECT: goto_elem(SX_CROP);
      SX_CROP: begin
        if (v == 0) post_size(ST_OK);
        else goto_elem(SX_CROP_L);
      end
      SX_CROP_L: begin
        p_crop_h = p_crop_h + v[17:0];
        goto_elem(SX_CROP_R);
      end
      SX_CROP_R: begin
        p_crop_h = p_crop_h + v[17:0];
        goto_elem(SX_CROP_T);
      end
      SX_CROP_T: begin
        p_crop_v = p_crop_v + v[17:0];
        goto_elem(SX_CROP_B);
      end
      SX_CROP_B: begin
        p_crop_v = p_crop_v + v[17:0];
        post_size(ST_OK);
      end
      default: ;
    endcase
  endtask

  task automatic parse_bit(logic b);
    if (p_prefix) begin
      // after fifteen zeros the next bit stops the prefix whatever it is
      if (!b && p_zeros < MaxZeros) begin
        p_zeros++;
      end else begin
        p_prefix = 1'b0;
        if (p_zeros == 0) elem_done('0);
        else begin
          p_bits_left = p_zeros;
          p_value = 32'd1;
        end
      end
    end else begin
      p_value = {p_value[30:0], b};
      if (p_bits_left > 0) p_bits_left--;
      if (p_bits_left == 0)
        elem_done(elem_bits(p_step) != 0 ? p_value : p_value - 32'd1);
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic last);
    for (int i = 7; i >= 0 && !p_done; i--) parse_bit(b[i]);
    if (last) begin
      if (!p_done) post_size(ST_TRUNC);
      clear_parse();
    end
  endtask

  // ---------------- driving ----------------
  // called and returning at a falling edge; valid stays high between items unless random idle cycles are drawn
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i = b;
    last_byte_i = last;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) bit_buf.push_back(v[i]);
  endtask

  task automatic put_ue(logic [31:0] v);
    logic [31:0] code;
    int n;
    code = v + 1;
    n = $clog2(code + 1);
    put_bits(0, n - 1);
    put_bits(code, n);
  endtask

  task automatic put_se(int d);
    put_ue(d > 0 ? 2 * d - 1 : -2 * d);
  endtask

  // pads the bit buffer to whole bytes and sends it; keep < 0 sends all,
  // otherwise the unit is cut after that many bytes, but never below one
  task automatic flush_nal(int keep);
    logic [7:0] b;
    int nb;
    while (bit_buf.size() % 8 != 0) bit_buf.push_back(1'($urandom));
    nb = bit_buf.size() / 8;
    if (keep >= 0 && keep < nb) nb = keep;
    if (nb == 0) nb = 1;
    for (int k = 0; k < nb; k++) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], bit_buf.size() ? bit_buf.pop_front() : 1'b0};
      send_byte(b, k == nb - 1);
    end
    bit_buf.delete();
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return $urandom_range(65534);
      1: return $urandom_range(1023);
      default: return $urandom_range(120);
    endcase
  endfunction

  // one well-formed sps with random content
  task automatic build_sps(logic [7:0] prof, logic [7:0] lvl);
    int last, nxt, d, sz;
    logic [31:0] poc, cyc;
    put_bits({3'($urandom), 5'd7}, 8);
    put_bits(prof, 8);
    put_bits($urandom, 8);
    put_bits(lvl, 8);
    put_ue($urandom_range(31));
    if (prof == ProfHigh || prof == ProfHigh10 || prof == ProfHigh422 ||
        prof == ProfHigh444) begin
      d = $urandom_range(3);
      put_ue(d);
      if (d == 3) put_bits($urandom, 1);
      put_ue($urandom_range(6));
      put_ue($urandom_range(6));
      put_bits($urandom, 1);
      if ($urandom_range(1)) begin
        put_bits(1, 1);
        for (int l = 0; l < 8; l++) begin
          if ($urandom_range(1)) begin
            put_bits(1, 1);
            last = 8;
            sz = l < 6 ? 16 : 64;
            for (int p = 0; p < sz; p++) begin
              // now and then steer the walk to zero to end the list early
              d = $urandom_range(19) == 0 ? -last : $urandom_range(40) - 20;
              put_se(d);
              nxt = (last + d) & 255;
              if (nxt == 0) break;
              last = nxt;
            end
          end else put_bits(0, 1);
        end
      end else put_bits(0, 1);
    end
    put_ue($urandom_range(12));
    poc = $urandom_range(3);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(12));
    else if (poc == 1) begin
      put_bits($urandom, 1);
      put_se($urandom_range(200) - 100);
      put_se($urandom_range(200) - 100);
      cyc = $urandom_range(4);
      put_ue(cyc);
      for (int c = 0; c < cyc; c++) put_se($urandom_range(60) - 30);
    end
    put_ue($urandom_range(16));
    put_bits($urandom, 1);
    put_ue(pick_size());
    put_ue(pick_size());
    d = $urandom_range(1);
    put_bits(d, 1);
    if (d == 0) put_bits($urandom, 1);
    put_bits($urandom, 1);
    if ($urandom_range(1)) begin
      put_bits(1, 1);
      for (int c = 0; c < 4; c++) put_ue($urandom_range(3) == 0 ? pick_size() : $urandom_range(8));
    end else put_bits(0, 1);
    // trailing bytes after the result are ignored by the parser
    put_bits($urandom, 8 * $urandom_range(2));
  endtask

  function automatic logic [7:0] pick_profile();
    case ($urandom_range(6))
      0: return 8'd66;
      1: return 8'd77;
      2: return ProfHigh;
      3: return ProfHigh10;
      4: return ProfHigh422;
      5: return ProfHigh444;
      default: return 8'($urandom);
    endcase
  endfunction

  // sender goes idle so the accepted byte is not offered again
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_sizes.size() != 0) @(negedge clk_i);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    // wrong nal type, and a byte stream that keeps going after the result
    put_bits(8'h68, 8); put_bits(8'hFF, 8); put_bits(8'h00, 8); flush_nal(-1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // level just above the limit and the largest level byte
    put_bits(8'h67, 8); put_bits(8'd66, 8); put_bits(8'h00, 8); put_bits(8'd52, 8);
    flush_nal(-1);
    put_bits(8'h67, 8); put_bits(8'hFF, 8); put_bits(8'hFF, 8); put_bits(8'hFF, 8);
    flush_nal(-1);
    // header alone, then a unit cut short after six bytes
    put_bits(8'h67, 8); flush_nal(-1);
    build_sps(8'd66, 8'd51); flush_nal(6);
    // smallest picture, level zero, no crop
    put_bits(8'h67, 8); put_bits(8'd66, 8); put_bits(8'h00, 8); put_bits(8'd0, 8);
    put_ue(0); put_ue(0); put_ue(2); put_ue(0); put_bits(0, 1);
    put_ue(0); put_ue(0); put_bits(3'b110, 3); flush_nal(-1);
    // largest coded sizes; the crop values follow a clear crop flag and are ignored
    put_bits(8'hE7, 8); put_bits(8'd77, 8); put_bits(8'h00, 8); put_bits(8'd40, 8);
    put_ue(0); put_ue(0); put_ue(2); put_ue(0); put_bits(0, 1);
    put_ue(65534); put_ue(65534); put_bits(3'b011, 3);
    put_ue(65534); put_ue(65534); put_ue(65534); put_ue(65534); flush_nal(-1);
    // long prefix: sixteen zeros, the stop bit taken as a one anyway
    put_bits(8'h67, 8); put_bits(8'd66, 8); put_bits(8'h00, 8); put_bits(8'd30, 8);
    put_bits(0, 16); put_bits(16'h5A5A, 15); put_ue(0); put_ue(2); put_ue(0);
    put_bits(0, 1); put_ue(10); put_ue(7); put_bits(3'b101, 3); flush_nal(-1);
    // every high profile, with scaling lists and poc type drawn at random
    build_sps(ProfHigh, 8'd31); flush_nal(-1);
    build_sps(ProfHigh10, 8'd42); flush_nal(-1);
    build_sps(ProfHigh422, 8'd51); flush_nal(-1);
    build_sps(ProfHigh444, 8'd20); flush_nal(-1);
    wait_drained();
  endtask

  task automatic test_random(int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      case ($urandom_range(9))
        0: begin
          // noise
          for (int k = $urandom_range(5); k >= 0; k--) send_byte(8'($urandom), k == 0);
        end
        1: begin
          build_sps(pick_profile(), 8'($urandom));
          flush_nal(-1);
        end
        2: begin
          build_sps(pick_profile(), 8'($urandom_range(51)));
          flush_nal($urandom_range(1, 12));
        end
        default: begin
          build_sps(pick_profile(), 8'($urandom_range(51)));
          flush_nal(-1);
        end
      endcase
    end
  endtask

  // receiver holds off while short bad-type units keep coming, so the
  // output register fills and the input stalls
  task automatic test_backpressure();
    hold_cycles = 300;
    while (hold_cycles > 0) send_byte({3'($urandom), 5'd1}, 1'b1);
    // sender waits until every result is out before going on
    wait_drained();
    test_random(20);
    wait_drained();
  endtask

  // ---------------- receiver side ----------------
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // compare each output item with the oldest predicted size
  always @(posedge clk_i) begin
    sps_size_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{sps_status_e'(status_o), profile_o, level_o, coded_width_o,
              coded_height_o, disp_width_o, disp_height_o};
      if (pending_sizes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        want = pending_sizes.pop_front();
        if (got.status !== want.status || got.profile !== want.profile ||
            got.level !== want.level || got.coded_w !== want.coded_w ||
            got.coded_h !== want.coded_h || got.disp_w !== want.disp_w ||
            got.disp_h !== want.disp_h) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_parse();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(40);
    wait_drained();
    send_idle_pct = 49;
    test_random(40);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(40);
    wait_drained();
    send_idle_pct = 34;
    recv_stall_pct = 34;
    test_random(40);
    test_backpressure();
    in_valid_i = 1'b0;
    wait_drained();
    repeat (30) @(negedge clk_i);
    if (mismatches == 0 && pending_sizes.size() == 0) begin
      $display("tb: success");
    end else begin
      if (pending_sizes.size() != 0) $display("%0d items never came", pending_sizes.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: avc_sps_size_parser.f
src/avc_sps_pkg.sv
src/avc_sps_ctrl.sv
src/avc_sps_dp.sv
src/avc_sps_size_parser.sv
test/avc_sps_size_parser_tb.sv
